[sv/cd_pkg.sv]
// ---------------------------------------------------------------------------
// cd_pkg: shared types and constants of the circular deque
// Word formats, operation and status codes, store geometry and the helper
// that turns the depth register into the last usable slot index.
// ---------------------------------------------------------------------------
`default_nettype none

package cd_pkg;

   // Store geometry
   localparam int MAX_DEPTH = 16;
   localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
   localparam int CFG_W     = 5;
   localparam int DW        = (CFG_W > CNT_W) ? CFG_W : CNT_W;
   localparam int WORD_W    = 32;

   localparam logic [CFG_W-1:0] DEPTH_RESET = CFG_W'(16);

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] data_in;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] data_out;
      status_type         status;
      logic               now_empty;
      logic               now_full;
   } rsp_word_type;

   // Clamp the depth register to 1..MAX_DEPTH and return the last slot index
   function automatic logic [IDX_W-1:0] last_index(input logic [CFG_W-1:0] value);
      logic [DW-1:0] wide;
      wide = DW'(value);
      if (wide == '0) begin
         return '0;
      end
      if (wide > DW'(MAX_DEPTH)) begin
         return IDX_W'(MAX_DEPTH - 1);
      end
      return IDX_W'(wide - DW'(1));
   endfunction

endpackage

`default_nettype wire

[sv/cd_ram.sv]
// ---------------------------------------------------------------------------
// cd_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module cd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write, and register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sv/circular_deque.sv]
// ---------------------------------------------------------------------------
// circular_deque: double-ended queue of signed 32-bit words
// Words sit in a circular RAM; head/tail indices and the empty flag live in
// registers. Push and pop at either end, depth set by a control register.
// ---------------------------------------------------------------------------
// The result word appears in the cycle after start is taken. Throughput is
// one operation per cycle unless busy; pops read the RAM in the accept
// cycle and its registered read port delivers the word in the result cycle.
// busy is high during reset and while a depth write is offered on the csr port.
// Reset: synchronous; the deque is empty, both indices 0, depth 16.
// The result channel cannot be stalled.
`default_nettype none

module circular_deque
   import cd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   output rsp_word_type      rsp_word,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [4:0]   csr_data
);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0] last_ff;
   logic             empty_ff, empty_in;
   logic             rsp_valid_ff;
   logic             from_ram_ff, from_ram_in;
   logic [31:0]      const_ff, const_in;
   status_type       status_ff, status_in;
   logic             now_empty_ff, now_full_ff, now_full_in;

   logic             accept;
   logic             csr_write;
   logic             full_now;
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [31:0]      rd_data;

   // Wrap-around step helpers
   function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i,
                                                input logic [IDX_W-1:0] last);
      return (i == last) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i,
                                                  input logic [IDX_W-1:0] last);
      return (i == '0) ? last : i - IDX_W'(1);
   endfunction

   // Hold off commands and depth writes while in reset
   assign csr_ready = !reset;
   assign csr_write = csr_valid && csr_ready;
   assign busy      = csr_valid || reset;
   assign accept    = start && !busy;
   assign full_now  = !empty_ff && (step_up(tail_ff, last_ff) == head_ff);

   // Decide the operation against the current indices
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      empty_in    = empty_ff;
      status_in   = ST_DONE;
      const_in    = '0;
      from_ram_in = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      rd_en       = 1'b0;
      rd_addr     = head_ff;
      case (req_word.operation)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (full_now) begin
               status_in = ST_FULL;
            end else if (empty_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
               wr_en    = accept;
               wr_addr  = '0;
            end else if (req_word.operation == OP_PUSH_FRONT) begin
               head_in = step_down(head_ff, last_ff);
               wr_en   = accept;
               wr_addr = head_in;
            end else begin
               tail_in = step_up(tail_ff, last_ff);
               wr_en   = accept;
               wr_addr = tail_in;
            end
         end
         OP_POP_FRONT, OP_POP_REAR: begin
            if (empty_ff) begin
               status_in = ST_EMPTY;
               const_in  = '1;
            end else begin
               from_ram_in = 1'b1;
               rd_en       = accept;
               rd_addr     = (req_word.operation == OP_POP_FRONT) ? head_ff : tail_ff;
               if (head_ff == tail_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else if (req_word.operation == OP_POP_FRONT) begin
                  head_in = step_up(head_ff, last_ff);
               end else begin
                  tail_in = step_down(tail_ff, last_ff);
               end
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
      now_full_in = !empty_in && (step_up(tail_in, last_ff) == head_in);
   end

   // Hold indices and depth, register the result word
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         last_ff      <= last_index(DEPTH_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (csr_write) begin
            last_ff  <= last_index(csr_data);
            head_ff  <= '0;
            tail_ff  <= '0;
            empty_ff <= 1'b1;
         end else if (accept) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            empty_ff <= empty_in;
         end
      end
      if (accept) begin
         from_ram_ff  <= from_ram_in;
         const_ff     <= const_in;
         status_ff    <= status_in;
         now_empty_ff <= empty_in;
         now_full_ff  <= now_full_in;
      end
   end

   cd_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_word.data_in),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Drive the result word
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_word.data_out  = from_ram_ff ? rd_data : const_ff;
   assign rsp_word.status    = status_ff;
   assign rsp_word.now_empty = now_empty_ff;
   assign rsp_word.now_full  = now_full_ff;

   // Every result word follows exactly one accepted command
   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept))
      else $error("result word without accepted command");

   // Empty and full never reported together
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.now_empty && rsp_word.now_full))
      else $error("empty and full both set");

   // An empty deque parks both indices at slot 0
   a_empty_parks: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0) && (tail_ff == '0))
      else $error("indices not parked while empty");

   // A refused push leaves the indices untouched
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == ST_FULL) |-> ($stable(head_ff) && $stable(tail_ff)))
      else $error("refused push moved an index");

endmodule

`default_nettype wire
